// ----- hdl/lpfp_pkg.sv -----
// Shared types and constants for the length-prefixed frame parser.
// Used by the output channel interface and every module of the parser; no dependencies.
package lpfp_pkg;

  localparam int unsigned LEN_BYTES = 4;
  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned MIN_DATA_LEN = 1 + HDR_BYTES;
  localparam int unsigned MAX_LEN_W = 25;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 25'd65536;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] CMD_DATA = 8'd1;
  localparam logic [7:0] CMD_END  = 8'd2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERR   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_LEN = 4'b0001,
    PH_CMD = 4'b0010,
    PH_HDR = 4'b0100,
    PH_DAT = 4'b1000
  } phase_t;

  // One classified result on its way from the parser to the output stage.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] idx;
    logic [31:0] rows;
    logic [31:0] cols;
  } q_entry_t;

endpackage

// ----- hdl/lpfp_if.sv -----
// Valid/ready channel interfaces for the parser's byte input and result output.
// Depends on lpfp_pkg for the result kind type.
interface lpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfp_out_if;
  import lpfp_pkg::*;

  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [7:0]         payload_byte;
  logic signed [31:0] frame_index;
  logic signed [31:0] row_count;
  logic signed [31:0] col_count;
  logic               last;

  modport source (output valid, output kind, output payload_byte, output frame_index,
                  output row_count, output col_count, output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input frame_index,
                  input row_count, input col_count, input last, output ready);
endinterface

// ----- hdl/lpfp_front.sv -----
// Parser front end: accepts bytes, tracks frame phase and pushes classified results.
// Depends on lpfp_pkg and lpfp_in_if.
module lpfp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  lpfp_in_if.sink                       in_ch,
  input  logic [lpfp_pkg::MAX_LEN_W-1:0] max_len,
  input  logic                          q_full,
  output logic                          push,
  output lpfp_pkg::q_entry_t            push_entry
);
  import lpfp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [31:0] rows_r, rows_nxt;
  logic [31:0] cols_r, cols_nxt;
  logic        accept;
  logic [3:0]  cnt_inc;
  logic [4:0]  lane;
  logic [7:0]  b;
  logic [31:0] rem_dec;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign cnt_inc     = cnt_r + 4'd1;
  assign lane        = {cnt_r[1:0], 3'b000};
  assign rem_dec     = (rem_r != 32'd0) ? rem_r - 32'd1 : 32'd0;

  always_comb begin
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    len_nxt         = len_r;
    rem_nxt         = rem_r;
    idx_nxt         = idx_r;
    rows_nxt        = rows_r;
    cols_nxt        = cols_r;
    push            = 1'b0;
    push_entry.kind = KIND_DATA;
    push_entry.data = 8'd0;
    push_entry.last = 1'b1;
    if (accept) begin
      unique case (phase_r)
        PH_CMD: begin
          phase_nxt = PH_LEN;
          cnt_nxt   = 4'd0;
          if (b == CMD_DATA) begin
            if (len_r < 32'(MIN_DATA_LEN)) begin
              push            = 1'b1;
              push_entry.kind = KIND_ERR;
            end else begin
              rem_nxt   = len_r - 32'(MIN_DATA_LEN);
              phase_nxt = PH_HDR;
            end
          end else if (b == CMD_END) begin
            push            = 1'b1;
            push_entry.kind = KIND_END;
          end
        end
        PH_HDR: begin
          case (cnt_r[3:2])
            2'd0:    idx_nxt[lane +: 8]  = b;
            2'd1:    rows_nxt[lane +: 8] = b;
            default: cols_nxt[lane +: 8] = b;
          endcase
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 4'(HDR_BYTES)) begin
            cnt_nxt = 4'd0;
            if (rem_r == 32'd0) begin
              phase_nxt       = PH_LEN;
              push            = 1'b1;
              push_entry.kind = KIND_EMPTY;
            end else begin
              phase_nxt = PH_DAT;
            end
          end
        end
        PH_DAT: begin
          rem_nxt         = rem_dec;
          push            = 1'b1;
          push_entry.kind = KIND_DATA;
          push_entry.data = b;
          push_entry.last = (rem_dec == 32'd0);
          if (rem_dec == 32'd0) begin
            phase_nxt = PH_LEN;
            cnt_nxt   = 4'd0;
          end
        end
        default: begin
          phase_nxt = PH_LEN;
          len_nxt   = ((cnt_r[1:0] == 2'd0) ? 32'd0 : len_r) | ({24'd0, b} << lane);
          cnt_nxt   = cnt_inc;
          if (cnt_inc >= 4'(LEN_BYTES)) begin
            cnt_nxt = 4'd0;
            if (len_nxt == 32'd0 || len_nxt > {7'd0, max_len}) begin
              push            = 1'b1;
              push_entry.kind = KIND_ERR;
            end else begin
              phase_nxt = PH_CMD;
            end
          end
        end
      endcase
    end
    // Empty-frame results carry the header just completed.
    push_entry.idx  = idx_nxt;
    push_entry.rows = rows_nxt;
    push_entry.cols = cols_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      cnt_r   <= 4'd0;
      len_r   <= 32'd0;
      rem_r   <= 32'd0;
      idx_r   <= 32'd0;
      rows_r  <= 32'd0;
      cols_r  <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
    end
  end

endmodule

// ----- hdl/lpfp_queue.sv -----
// Short result queue between the parser front end and the output stage.
// Depends on lpfp_pkg for the entry type.
module lpfp_queue #(
  parameter int unsigned DEPTH = lpfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpfp_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output lpfp_pkg::q_entry_t pop_entry
);
  import lpfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/lpfp_back.sv -----
// Output stage: drains the result queue, formats fields by kind and holds them
// in a register until taken. Depends on lpfp_pkg and lpfp_out_if.
module lpfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lpfp_pkg::q_entry_t q_entry,
  output logic               pop,
  lpfp_out_if.source         out_ch
);
  import lpfp_pkg::*;

  logic        valid_r;
  kind_t       kind_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic [31:0] idx_r, rows_r, cols_r;
  logic        has_hdr;

  // Advance when the register is empty or its result is being taken.
  assign pop     = q_valid && (!valid_r || out_ch.ready);
  assign has_hdr = (q_entry.kind == KIND_DATA) || (q_entry.kind == KIND_EMPTY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= q_entry.kind;
      data_r <= (q_entry.kind == KIND_DATA) ? q_entry.data : 8'd0;
      last_r <= q_entry.last;
      idx_r  <= has_hdr ? q_entry.idx  : 32'd0;
      rows_r <= has_hdr ? q_entry.rows : 32'd0;
      cols_r <= has_hdr ? q_entry.cols : 32'd0;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.payload_byte = data_r;
  assign out_ch.last         = last_r;
  assign out_ch.frame_index  = idx_r;
  assign out_ch.row_count    = rows_r;
  assign out_ch.col_count    = cols_r;

endmodule

// ----- hdl/length_prefixed_frame_parser.sv -----
// Length-prefixed frame parser, top level.
// Bytes enter on in_ch (valid/ready, one byte per accepted request). Each frame is
// a 4-byte little-endian length, a command byte and, for data frames, a 12-byte
// header of index, rows and columns followed by the payload.
// Results leave on out_ch: payload bytes with header values (last on the final
// byte), end events, frame errors and empty-data events.
// cfg_we/cfg_wdata write the largest accepted length; write only while idle.
// Throughput: one byte per cycle while the queue is not full. A byte's result
// is queued on acceptance and is visible once loaded into the output register.
// The parser pushes into a small queue that the output stage drains; when the
// receiver stalls, the queue fills and in_ch.ready drops only once it is full,
// so no result is lost. Reset (rst_n, synchronous) returns the parser to the
// length field, empties the queue and sets the maximum length to 65536.
// Depends on lpfp_pkg, lpfp_if, lpfp_front, lpfp_queue and lpfp_back.
module length_prefixed_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = lpfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lpfp_in_if.sink                        in_ch,
  lpfp_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [lpfp_pkg::MAX_LEN_W-1:0] cfg_wdata
);
  import lpfp_pkg::*;

  logic [MAX_LEN_W-1:0] max_len_r;
  logic                 q_full;
  logic                 push;
  q_entry_t             push_entry;
  logic                 pop;
  logic                 q_valid;
  q_entry_t             q_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  lpfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .max_len    (max_len_r),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  lpfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_valid),
    .pop_entry  (q_entry)
  );

  lpfp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
